@@ rtl/flex_angle_filter_calibrator_assert.svh @@
`ifndef FLEX_ANGLE_FILTER_CALIBRATOR_ASSERT_SVH
`define FLEX_ANGLE_FILTER_CALIBRATOR_ASSERT_SVH
// concurrent assertion helpers
`define FAFC_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define FAFC_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ rtl/fafc_pkg.sv @@
package fafc_pkg;
  localparam int ANGLE_MAX = 23040;
  localparam logic [2:0] CMD_SAMPLE = 3'd0;
  localparam logic [2:0] CMD_FLAT = 3'd1;
  localparam logic [2:0] CMD_BENT = 3'd2;
  localparam logic [2:0] CMD_RESET = 3'd3;
  localparam logic [2:0] CMD_PRIME = 3'd4;
  localparam logic [1:0] REG_FILTER = 2'd0;
  localparam logic [1:0] REG_MIN_SPAN = 2'd1;
  localparam logic [1:0] REG_DEF_FLAT = 2'd2;
  localparam logic [1:0] REG_DEF_BENT = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] joint;
    logic [11:0] sample;
  } in_t;

  typedef struct packed {
    logic [11:0] filtered_value;
    logic [14:0] angle;
    logic fallback_used;
  } out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0] command;
    logic [3:0] joint;
    logic [11:0] sample;
    logic skip;
  } job_t;
endpackage

@@ rtl/fafc_front.sv @@
module fafc_front #(
  parameter int JOINTS = 10
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input fafc_pkg::in_t in_data,
  output logic q_valid,
  input logic q_ready,
  output fafc_pkg::job_t q_data
);
  import fafc_pkg::*;
  localparam int QD = 2;
  job_t q [QD];
  logic rd;
  logic wr_ptr;
  logic [1:0] count;
  job_t job;

  always_comb begin
    job.command = in_data.command;
    job.joint = in_data.joint;
    job.sample = in_data.sample;
    job.skip = (in_data.command != CMD_RESET) && (32'(in_data.joint) >= JOINTS);
  end

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data = q[rd];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q[wr_ptr] <= job;
    if (rst) begin
      rd <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd <= ~rd;
      count <= count + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule

@@ rtl/fafc_back.sv @@
module fafc_back #(
  parameter int JOINTS = 10,
  parameter int WINDOW = 5,
  parameter int SAMPLE_BITS = 12
) (
  input logic clk,
  input logic rst,
  input logic q_valid,
  output logic q_ready,
  input fafc_pkg::job_t q_data,
  input logic filter_enable,
  input logic [11:0] min_span,
  input logic [11:0] default_flat,
  input logic [11:0] default_bent,
  output logic out_valid,
  input logic out_ready,
  output fafc_pkg::out_t out_data
);
  import fafc_pkg::*;
  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1) + 1;
  localparam int SUMW = 12 + $clog2(WINDOW + 1);
  localparam int AW = (JOINTS * WINDOW > 1) ? $clog2(JOINTS * WINDOW) : 1;
  localparam int RSH = 21;
  localparam int PW = SUMW + RSH + 1;
  localparam logic [RSH:0] RECIP = (RSH+1)'(((32'd1 << RSH) + WINDOW - 1) / WINDOW);
  localparam logic [11:0] SMASK = 12'((32'd1 << SAMPLE_BITS) - 1);
  localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_SUM = 4'd2, S_DIVW = 4'd3,
    S_UPD = 4'd4, S_MUL = 4'd5, S_DIV = 4'd6, S_PRIME = 4'd7, S_OUT = 4'd8;

  logic [3:0] state;
  job_t job;
  logic [JW-1:0] jix;
  logic [11:0] win [JOINTS*WINDOW];
  logic [JOINTS*WINDOW-1:0] wok;
  logic [SW-1:0] slot [JOINTS];
  logic [11:0] cap_flat [JOINTS];
  logic [11:0] act_flat [JOINTS];
  logic [11:0] act_bent [JOINTS];
  logic [CW-1:0] cnt;
  logic [SUMW-1:0] sum;
  logic [11:0] rd_word;
  logic [11:0] raw;
  logic [11:0] f;
  logic fb;
  logic [11:0] den;
  logic [26:0] rem_num;
  logic [26:0] quo;
  logic [11:0] acc;
  logic [4:0] bits;
  logic [11:0] span;
  logic [12:0] diff;
  logic zero;
  logic [AW-1:0] base, rd_addr, ld_addr;
  logic [PW-1:0] mean_prod;

  assign raw = job.sample & SMASK;
  assign q_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign span = (f >= cap_flat[jix]) ? f - cap_flat[jix] : cap_flat[jix] - f;
  assign diff = {1'b0, f} - {1'b0, act_flat[jix]};
  assign base = AW'(32'(jix) * WINDOW);
  assign rd_addr = base + AW'(cnt[SW-1:0]);
  assign ld_addr = base + AW'(slot[jix]);
  // mean by reciprocal multiply
  assign mean_prod = PW'(sum) * PW'(RECIP);

  always_ff @(posedge clk) begin
    rd_word <= wok[rd_addr] ? win[rd_addr] : '0;
    if (rst) begin
      state <= S_IDLE;
      wok <= '0;
      for (int j = 0; j < JOINTS; j++) begin
        slot[j] <= '0;
        cap_flat[j] <= 12'd2000;
        act_flat[j] <= 12'd2000;
        act_bent[j] <= 12'd3500;
      end
      cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          job <= q_data;
          jix <= JW'(q_data.joint);
          fb <= 1'b0;
          out_data <= '0;
          if (q_data.command == CMD_RESET) begin
            for (int j = 0; j < JOINTS; j++) begin
              cap_flat[j] <= default_flat;
              act_flat[j] <= default_flat;
              act_bent[j] <= default_bent;
            end
            state <= S_OUT;
          end else if (q_data.skip) state <= S_OUT;
          else state <= S_LOAD;
        end
        S_LOAD: begin
          if (filter_enable) begin
            win[ld_addr] <= raw;
            wok[ld_addr] <= 1'b1;
            slot[jix] <= (32'(slot[jix]) == WINDOW - 1) ? '0 : slot[jix] + 1'b1;
            cnt <= '0;
            sum <= '0;
            state <= S_SUM;
          end else begin
            f <= raw;
            state <= S_UPD;
          end
        end
        S_SUM: begin
          if (cnt != '0) sum <= sum + SUMW'(rd_word);
          if (32'(cnt) == WINDOW) state <= S_DIVW;
          cnt <= cnt + 1'b1;
        end
        S_DIVW: begin
          f <= mean_prod[RSH +: 12] & SMASK;
          state <= S_UPD;
        end
        S_UPD: begin
          if (job.command == CMD_FLAT) cap_flat[jix] <= f;
          else if (job.command == CMD_BENT) begin
            if (span < min_span) begin
              cap_flat[jix] <= default_flat;
              act_flat[jix] <= default_flat;
              act_bent[jix] <= default_bent;
              fb <= 1'b1;
            end else begin
              act_flat[jix] <= cap_flat[jix];
              act_bent[jix] <= f;
            end
          end
          cnt <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          zero <= (diff == '0) || (act_bent[jix] == act_flat[jix]) ||
                  ((act_bent[jix] < act_flat[jix]) != diff[12]);
          den <= (act_bent[jix] >= act_flat[jix]) ? act_bent[jix] - act_flat[jix]
                                                  : act_flat[jix] - act_bent[jix];
          rem_num <= 27'(ANGLE_MAX) * 27'(diff[12] ? 13'(-diff) : diff);
          acc <= '0;
          bits <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (bits == 5'd27) begin
            out_data.filtered_value <= f;
            out_data.fallback_used <= fb;
            if (zero) out_data.angle <= '0;
            else out_data.angle <= (quo > 27'(ANGLE_MAX)) ? 15'(ANGLE_MAX) : quo[14:0];
            cnt <= '0;
            state <= (job.command == CMD_PRIME) ? S_PRIME : S_OUT;
          end else begin
            if ({acc, rem_num[26]} >= {1'b0, den}) begin
              acc <= 12'({acc, rem_num[26]} - {1'b0, den});
              quo <= {quo[25:0], 1'b1};
            end else begin
              acc <= {acc[10:0], rem_num[26]};
              quo <= {quo[25:0], 1'b0};
            end
            rem_num <= {rem_num[25:0], 1'b0};
            bits <= bits + 1'b1;
          end
        end
        S_PRIME: begin
          win[rd_addr] <= f;
          wok[rd_addr] <= 1'b1;
          slot[jix] <= '0;
          cnt <= cnt + 1'b1;
          if (32'(cnt) == WINDOW - 1) state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/flex_angle_filter_calibrator.sv @@
// channel  | direction | handshake
// in       | input     | in_valid / in_ready
// out      | output    | out_valid / out_ready
// cfg      | input     | cfg_we, one register per index
// the back end holds an item while it works: with filtering on it sums the window,
// takes the mean by reciprocal multiply and runs a 27-step bit-serial divide for
// the angle; filtering off skips window and mean; prime then fills the window.
// reset calibration and out-of-range joints go straight to output; out_ready low
// holds the item. a two-entry queue lets the front accept while the back works.
// rst is synchronous, restores all calibration; windows read as zero until written
module flex_angle_filter_calibrator #(
  parameter int JOINTS = 10,
  parameter int WINDOW = 5,
  parameter int SAMPLE_BITS = 12
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input fafc_pkg::in_t in_data,
  output logic out_valid,
  input logic out_ready,
  output fafc_pkg::out_t out_data,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [11:0] cfg_data
);
  import fafc_pkg::*;
  logic filter_enable;
  logic [11:0] min_span, default_flat, default_bent;
  logic q_valid, q_ready;
  job_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b1;
      min_span <= 12'd100;
      default_flat <= 12'd2000;
      default_bent <= 12'd3500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER: filter_enable <= cfg_data[0];
        REG_MIN_SPAN: min_span <= cfg_data;
        REG_DEF_FLAT: default_flat <= cfg_data;
        REG_DEF_BENT: default_bent <= cfg_data;
      endcase
    end
  end

  fafc_front #(.JOINTS(JOINTS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data, .q_valid, .q_ready, .q_data
  );

  fafc_back #(.JOINTS(JOINTS), .WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data, .filter_enable, .min_span,
    .default_flat, .default_bent, .out_valid, .out_ready, .out_data
  );
endmodule

@@ rtl/fafc_checker.sv @@
`include "flex_angle_filter_calibrator_assert.svh"
module fafc_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input fafc_pkg::out_t out_data
);
  import fafc_pkg::*;
  `FAFC_ASSERT_IMP(a_angle_max, clk, rst, out_valid, out_data.angle <= 15'(ANGLE_MAX))
  `FAFC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `FAFC_ASSERT_NXT(a_one_cycle_gap, clk, rst, out_valid && out_ready, !out_valid)
endmodule

bind flex_angle_filter_calibrator fafc_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
